// ===== rtl/cmfs_pkg.sv =====
// cmfs_pkg: shared types and constants of the cube map face select block
// no dependencies; imported by every module of the block
package cmfs_pkg;

  // fixed field widths
  localparam int unsigned COMP_W  = 16;
  localparam int unsigned FACE_W  = 3;
  localparam int unsigned TEXEL_W = 12;
  localparam int unsigned CFG_W   = 13;

  // face width after reset
  localparam logic [CFG_W-1:0] CFG_FACE_WIDTH_RESET = 13'd256;

  // register index, taken from paddr bit 2
  localparam logic REG_FACE_WIDTH = 1'b0;

  // cube faces
  typedef enum logic [FACE_W-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  // input item
  typedef struct packed {
    logic signed [COMP_W-1:0] dir_x;
    logic signed [COMP_W-1:0] dir_y;
    logic signed [COMP_W-1:0] dir_z;
  } dir_t;

  // result item
  typedef struct packed {
    face_e              face;
    logic [TEXEL_W-1:0] texel_x;
    logic [TEXEL_W-1:0] texel_y;
    logic               invalid;
  } res_t;

  // control that rides along the pipeline
  typedef struct packed {
    logic  valid;
    face_e face;
    logic  invalid;
  } ctl_t;

endpackage

// ===== rtl/cube_map_face_select_texel.sv =====
// cube_map_face_select_texel: top level, config register, divider chain, result register
// depends on cmfs_pkg, cmfs_front and cmfs_cell
//
// Usage:
//   An item (dir_i: dir_x, dir_y, dir_z) is taken at a rising edge with start high
//   and busy low. busy is high only in the first cycle after reset, so a new item
//   may enter in every cycle: one item per cycle sustained.
//   Each item gives one result on res_o, marked by res_valid_o for one cycle.
//   The result passes the front registers (stages a and b), the divider chain and the
//   result register (QB = clog2(MAX_FACE_WIDTH) quotient bits, so 12 at the default).
//   The divider chain has one cell per quotient bit, each cell resolving one bit of
//   both texel coordinates.
//   The receiver cannot stall; results appear in the order the items entered.
//   face_width is written through the APB port (byte address 0) while no item is
//   in flight; 0 acts as 1, values above MAX_FACE_WIDTH saturate.
//   Reset (rst_ni low, asynchronous) drops every item in flight and sets
//   face_width to 256.
module cube_map_face_select_texel import cmfs_pkg::*; #(
  parameter int unsigned MAX_FACE_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  dir_t        dir_i,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned QB    = $clog2(MAX_FACE_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_FACE_WIDTH + 1);
  localparam int unsigned NUM_W = COMP_W + 1 + QB;
  localparam int unsigned W_RST = (int'(CFG_FACE_WIDTH_RESET) > MAX_FACE_WIDTH) ?
                                  MAX_FACE_WIDTH : int'(CFG_FACE_WIDTH_RESET);

  logic             busy_q;
  logic             accept;
  logic             cfg_wr;
  logic [CFG_W-1:0] face_width_d, face_width_q;
  logic [WW-1:0]    w_eff_d, w_eff_q;

  ctl_t             ch_ctl [QB+1];
  logic [NUM_W-1:0] ch_dsh [QB+1];
  logic [NUM_W-1:0] ch_ru  [QB+1];
  logic [NUM_W-1:0] ch_rv  [QB+1];
  logic [QB-1:0]    ch_qu  [QB+1];
  logic [QB-1:0]    ch_qv  [QB+1];

  logic             res_valid_q;
  res_t             res_d, res_q;

  // handshake: busy only right after reset
  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // config port
  assign cfg_wr       = psel && penable && pwrite && (paddr[2] == REG_FACE_WIDTH);
  assign face_width_d = cfg_wr ? pwdata[CFG_W-1:0] : face_width_q;
  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == REG_FACE_WIDTH) ? 32'(face_width_q) : '0;

  // effective width: zero acts as one, saturate at the maximum
  always_comb begin
    if (face_width_q == '0) begin
      w_eff_d = WW'(1);
    end else if (32'(face_width_q) > 32'(MAX_FACE_WIDTH)) begin
      w_eff_d = WW'(MAX_FACE_WIDTH);
    end else begin
      w_eff_d = WW'(face_width_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b1;
      face_width_q <= CFG_FACE_WIDTH_RESET;
      w_eff_q      <= WW'(W_RST);
    end else begin
      busy_q       <= 1'b0;
      face_width_q <= face_width_d;
      w_eff_q      <= w_eff_d;
    end
  end

  // face select and numerators
  cmfs_front #(
    .QB   (QB),
    .WW   (WW),
    .NUM_W(NUM_W)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .dir_i   (dir_i),
    .width_i (w_eff_q),
    .ctl_o   (ch_ctl[0]),
    .num_u_o (ch_ru[0]),
    .num_v_o (ch_rv[0]),
    .dsh_o   (ch_dsh[0])
  );

  assign ch_qu[0] = '0;
  assign ch_qv[0] = '0;

  // divider chain, one quotient bit per cell
  for (genvar k = 0; k < QB; k++) begin : g_cell
    cmfs_cell #(
      .QB   (QB),
      .NUM_W(NUM_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ch_ctl[k]),
      .dsh_i  (ch_dsh[k]),
      .rem_u_i(ch_ru[k]),
      .q_u_i  (ch_qu[k]),
      .rem_v_i(ch_rv[k]),
      .q_v_i  (ch_qv[k]),
      .ctl_o  (ch_ctl[k+1]),
      .dsh_o  (ch_dsh[k+1]),
      .rem_u_o(ch_ru[k+1]),
      .q_u_o  (ch_qu[k+1]),
      .rem_v_o(ch_rv[k+1]),
      .q_v_o  (ch_qv[k+1])
    );
  end

  // result item, zero vector gives texel 0,0
  always_comb begin
    res_d.face    = ch_ctl[QB].face;
    res_d.invalid = ch_ctl[QB].invalid;
    res_d.texel_x = ch_ctl[QB].invalid ? '0 : TEXEL_W'(ch_qu[QB]);
    res_d.texel_y = ch_ctl[QB].invalid ? '0 : TEXEL_W'(ch_qv[QB]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ch_ctl[QB].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/cmfs_front.sv =====
// cmfs_front: major axis and face pick, then the two texel numerators
// depends on cmfs_pkg; feeds the divider chain of cmfs_cell stages
module cmfs_front import cmfs_pkg::*; #(
  parameter int unsigned QB    = 12,
  parameter int unsigned WW    = 13,
  parameter int unsigned NUM_W = 29
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  dir_t             dir_i,
  input  logic [WW-1:0]    width_i,
  output ctl_t             ctl_o,
  output logic [NUM_W-1:0] num_u_o,
  output logic [NUM_W-1:0] num_v_o,
  output logic [NUM_W-1:0] dsh_o
);

  localparam int unsigned MW = COMP_W + 1;
  localparam int unsigned PW = MW + WW;

  logic [MW-1:0] xe, ye, ze, nxe, nye, nze;
  logic [MW-1:0] ax, ay, az;
  logic          x_pos, y_pos, z_pos;

  ctl_t          a_ctl_d, a_ctl_q;
  logic [MW-1:0] a_m_d, a_m_q;
  logic [MW-1:0] a_nu_d, a_nu_q;
  logic [MW-1:0] a_nv_d, a_nv_q;

  logic [MW-1:0] s_u, s_v;
  logic [PW-1:0] prod_u, prod_v;
  logic [PW:0]   diff_u, diff_v;
  logic [MW-1:0] dbl_m;

  ctl_t             b_ctl_q;
  logic [NUM_W-1:0] b_num_u_d, b_num_u_q;
  logic [NUM_W-1:0] b_num_v_d, b_num_v_q;
  logic [NUM_W-1:0] b_dsh_d, b_dsh_q;

  // sign extend, negate and take magnitudes
  always_comb begin
    xe    = {dir_i.dir_x[COMP_W-1], dir_i.dir_x};
    ye    = {dir_i.dir_y[COMP_W-1], dir_i.dir_y};
    ze    = {dir_i.dir_z[COMP_W-1], dir_i.dir_z};
    nxe   = MW'(0) - xe;
    nye   = MW'(0) - ye;
    nze   = MW'(0) - ze;
    ax    = xe[MW-1] ? nxe : xe;
    ay    = ye[MW-1] ? nye : ye;
    az    = ze[MW-1] ? nze : ze;
    x_pos = !xe[MW-1] && (xe != '0);
    y_pos = !ye[MW-1] && (ye != '0);
    z_pos = !ze[MW-1] && (ze != '0);
  end

  // face select: x, then y, then z on ties; zero goes to the negative face
  always_comb begin
    a_ctl_d.valid   = accept_i;
    a_ctl_d.invalid = 1'b0;
    a_ctl_d.face    = FACE_PX;
    a_m_d           = '0;
    a_nu_d          = '0;
    a_nv_d          = '0;
    if ((ax == '0) && (ay == '0) && (az == '0)) begin
      a_ctl_d.invalid = 1'b1;
    end else if ((ax >= ay) && (ax >= az)) begin
      a_m_d  = ax;
      a_nv_d = nye;
      if (x_pos) begin
        a_ctl_d.face = FACE_PX;
        a_nu_d       = nze;
      end else begin
        a_ctl_d.face = FACE_NX;
        a_nu_d       = ze;
      end
    end else if ((ay >= ax) && (ay >= az)) begin
      a_m_d  = ay;
      a_nu_d = xe;
      if (y_pos) begin
        a_ctl_d.face = FACE_PY;
        a_nv_d       = ze;
      end else begin
        a_ctl_d.face = FACE_NY;
        a_nv_d       = nze;
      end
    end else begin
      a_m_d  = az;
      a_nu_d = xe;
      if (z_pos) begin
        a_ctl_d.face = FACE_PZ;
        a_nv_d       = nye;
      end else begin
        a_ctl_d.face = FACE_NZ;
        a_nv_d       = ye;
      end
    end
  end

  // numerators (n+m)*w - m, negative clamps to zero; divisor 2m aligned to the top bit
  always_comb begin
    s_u       = a_nu_q + a_m_q;
    s_v       = a_nv_q + a_m_q;
    prod_u    = PW'(s_u) * PW'(width_i);
    prod_v    = PW'(s_v) * PW'(width_i);
    diff_u    = {1'b0, prod_u} - (PW+1)'(a_m_q);
    diff_v    = {1'b0, prod_v} - (PW+1)'(a_m_q);
    b_num_u_d = diff_u[PW] ? '0 : NUM_W'(diff_u);
    b_num_v_d = diff_v[PW] ? '0 : NUM_W'(diff_v);
    dbl_m     = {a_m_q[MW-2:0], 1'b0};
    b_dsh_d   = NUM_W'(dbl_m) << (QB - 1);
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
      b_ctl_q <= '0;
    end else begin
      a_ctl_q <= a_ctl_d;
      b_ctl_q <= a_ctl_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    a_m_q     <= a_m_d;
    a_nu_q    <= a_nu_d;
    a_nv_q    <= a_nv_d;
    b_num_u_q <= b_num_u_d;
    b_num_v_q <= b_num_v_d;
    b_dsh_q   <= b_dsh_d;
  end

  assign ctl_o   = b_ctl_q;
  assign num_u_o = b_num_u_q;
  assign num_v_o = b_num_v_q;
  assign dsh_o   = b_dsh_q;

endmodule

// ===== rtl/cmfs_cell.sv =====
// cmfs_cell: one quotient bit of the restoring divider for both texel axes
// depends on cmfs_pkg; a row of these forms the divider chain
module cmfs_cell import cmfs_pkg::*; #(
  parameter int unsigned QB    = 12,
  parameter int unsigned NUM_W = 29
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctl_t             ctl_i,
  input  logic [NUM_W-1:0] dsh_i,
  input  logic [NUM_W-1:0] rem_u_i,
  input  logic [QB-1:0]    q_u_i,
  input  logic [NUM_W-1:0] rem_v_i,
  input  logic [QB-1:0]    q_v_i,
  output ctl_t             ctl_o,
  output logic [NUM_W-1:0] dsh_o,
  output logic [NUM_W-1:0] rem_u_o,
  output logic [QB-1:0]    q_u_o,
  output logic [NUM_W-1:0] rem_v_o,
  output logic [QB-1:0]    q_v_o
);

  logic             ge_u, ge_v;
  ctl_t             ctl_q;
  logic [NUM_W-1:0] dsh_d, dsh_q;
  logic [NUM_W-1:0] rem_u_d, rem_u_q, rem_v_d, rem_v_q;
  logic [QB-1:0]    q_u_d, q_u_q, q_v_d, q_v_q;

  // compare and subtract against the shifted divisor, shift in the quotient bit
  always_comb begin
    ge_u    = rem_u_i >= dsh_i;
    ge_v    = rem_v_i >= dsh_i;
    rem_u_d = ge_u ? (rem_u_i - dsh_i) : rem_u_i;
    rem_v_d = ge_v ? (rem_v_i - dsh_i) : rem_v_i;
    q_u_d   = QB'({q_u_i, ge_u});
    q_v_d   = QB'({q_v_i, ge_v});
    dsh_d   = dsh_i >> 1;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    dsh_q   <= dsh_d;
    rem_u_q <= rem_u_d;
    rem_v_q <= rem_v_d;
    q_u_q   <= q_u_d;
    q_v_q   <= q_v_d;
  end

  assign ctl_o   = ctl_q;
  assign dsh_o   = dsh_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign q_u_o   = q_u_q;
  assign q_v_o   = q_v_q;

endmodule

// ===== rtl/cmfs_checker.sv =====
// cmfs_checker: port-level assertions for the cube map face select block
// depends on cmfs_pkg; bound to cube_map_face_select_texel below
module cmfs_checker import cmfs_pkg::*; #(
  parameter int unsigned MAX_FACE_WIDTH = 4096
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic res_valid_o,
  input res_t res_o
);

  // edges from the accepting edge to the edge that takes the result
  localparam int unsigned LAT = $clog2(MAX_FACE_WIDTH) + 3;

  // every accepted item gives a result after the fixed latency
  a_item_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT res_valid_o)
    else $error("accepted item produced no result");

  // no result without an item accepted the fixed latency earlier
  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, LAT))
    else $error("result without accepted item");

  // zero vector reports face 0 at texel 0,0
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.invalid) |->
      (res_o.face == FACE_PX) && (res_o.texel_x == '0) && (res_o.texel_y == '0))
    else $error("invalid result with nonzero fields");

  // face code stays within the six faces
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.face <= FACE_NZ))
    else $error("face code out of range");

endmodule

bind cube_map_face_select_texel cmfs_checker #(
  .MAX_FACE_WIDTH(MAX_FACE_WIDTH)
) u_cmfs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

// ===== tb/sv/cube_map_face_select_texel_tb.sv =====
// cube_map_face_select_texel_tb: self-checking bench for the cube map face/texel lookup
// depends on cmfs_pkg and cube_map_face_select_texel; predicts each result and checks it
// over several face widths and sender idle rates
module cube_map_face_select_texel_tb;
  import cmfs_pkg::*;

  localparam int unsigned MAX_FACE_WIDTH = 4096;
  localparam int unsigned LATENCY       = $clog2(MAX_FACE_WIDTH) + 2;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS   = 50;
  localparam int unsigned NUM_PHASES    = 9;

  // pending item: direction plus a flag to wait for an empty pipeline first
  typedef struct packed {
    dir_t dir;
    logic drain;
  } backlog_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  dir_t        dir_i = '0;
  logic        res_valid_o;
  res_t        res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  backlog_t         dir_backlog [$];
  res_t             lookup_due [$];
  logic [CFG_W-1:0] face_width_cfg = CFG_FACE_WIDTH_RESET;
  int unsigned      idle_pct = 0;
  int unsigned      in_flight = 0;
  int unsigned      n_fail = 0;
  int unsigned      quiet_cycles = 0;
  res_t             want;

  cube_map_face_select_texel #(.MAX_FACE_WIDTH(MAX_FACE_WIDTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .dir_i      (dir_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk_i = ~clk_i;

  // floor(((n+m)*w - m) / 2m), clamped to 0..w-1
  function automatic logic [TEXEL_W-1:0] texel_coord(longint n, longint m, longint w);
    longint num, q;
    num = (n + m) * w - m;
    if (num < 0) return '0;
    q = num / (2 * m);
    if (q > w - 1) q = w - 1;
    return TEXEL_W'(q);
  endfunction

  // expected face and texel for one direction at a given face width
  function automatic res_t cube_lookup(dir_t d, logic [CFG_W-1:0] fw);
    longint x, y, z, ax, ay, az, w, m, nu, nv;
    res_t r;
    x = $signed(d.dir_x);
    y = $signed(d.dir_y);
    z = $signed(d.dir_z);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    w = fw;
    if (w < 1) w = 1;
    if (w > MAX_FACE_WIDTH) w = MAX_FACE_WIDTH;
    r = '0;
    // zero vector flags invalid, face 0 at texel 0,0
    if (ax == 0 && ay == 0 && az == 0) begin
      r.invalid = 1'b1;
      r.face = FACE_PX;
      return r;
    end
    // major axis with x, y, z priority on ties; zero sign counts as negative
    if (ax >= ay && ax >= az) begin
      m = ax;
      if (x > 0) begin
        r.face = FACE_PX; nu = -z; nv = -y;
      end else begin
        r.face = FACE_NX; nu = z; nv = -y;
      end
    end else if (ay >= az) begin
      m = ay;
      if (y > 0) begin
        r.face = FACE_PY; nu = x; nv = z;
      end else begin
        r.face = FACE_NY; nu = x; nv = -z;
      end
    end else begin
      m = az;
      if (z > 0) begin
        r.face = FACE_PZ; nu = x; nv = -y;
      end else begin
        r.face = FACE_NZ; nu = x; nv = y;
      end
    end
    r.texel_x = texel_coord(nu, m, w);
    r.texel_y = texel_coord(nv, m, w);
    return r;
  endfunction

  function automatic dir_t mk_dir(int x, int y, int z);
    dir_t d;
    d.dir_x = COMP_W'(x);
    d.dir_y = COMP_W'(y);
    d.dir_z = COMP_W'(z);
    return d;
  endfunction

  // random direction: full range, tiny values, ties, extremes or a dominant axis
  function automatic dir_t rand_direction();
    int comp [3];
    int extremes [6];
    int m, ax, k;
    extremes = '{-32768, -32767, -1, 0, 1, 32767};
    case ($urandom_range(9))
      0, 1, 2: begin
        for (k = 0; k < 3; k++) comp[k] = int'($urandom_range(65535)) - 32768;
      end
      3: begin
        for (k = 0; k < 3; k++) comp[k] = int'($urandom_range(8)) - 4;
      end
      4: begin
        // equal magnitudes with random signs
        m = $urandom_range(32768);
        for (k = 0; k < 3; k++) comp[k] = $urandom_range(1) ? m : -m;
        if ($urandom_range(1)) comp[$urandom_range(2)] = int'($urandom_range(65535)) - 32768;
      end
      5: begin
        for (k = 0; k < 3; k++) comp[k] = extremes[$urandom_range(5)];
      end
      default: begin
        // one axis dominates; minors anywhere in [-m, m], often on the edge
        ax = $urandom_range(2);
        m = $urandom_range(1, 32767);
        for (k = 0; k < 3; k++) begin
          if (k == ax) comp[k] = $urandom_range(1) ? m : -m;
          else if ($urandom_range(3) == 0) comp[k] = $urandom_range(1) ? m : -m;
          else comp[k] = int'($urandom_range(2 * m)) - m;
        end
      end
    endcase
    return mk_dir(comp[0], comp[1], comp[2]);
  endfunction

  task automatic add_item(dir_t d, logic drain);
    backlog_t b;
    b.dir = d;
    b.drain = drain;
    dir_backlog.push_back(b);
  endtask

  task automatic flag_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
    n_fail++;
    if (n_fail <= MAX_REPORTS)
      $display("%0t mismatch %s: expected %0d, got %0d", $time, what, exp_v, got_v);
  endtask

  // wait until no item is queued, driven or in flight; checked mid-cycle once all
  // updates of the rising edge have settled
  task automatic wait_drained();
    do @(negedge clk_i); while (dir_backlog.size() != 0 || start || lookup_due.size() != 0);
  endtask

  // write face_width over apb, then read it back
  task automatic program_face_width(logic [CFG_W-1:0] val);
    logic [31:0] rd;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_FACE_WIDTH, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    face_width_cfg = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    do @(posedge clk_i); while (0);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[CFG_W-1:0] !== val) flag_field("face_width readback", 32'(val), rd);
  endtask

  // driver: holds an item until taken, then loads the next or idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      dir_i <= '0;
    end else begin
      if (start && !busy) begin
        lookup_due.push_back(cube_lookup(dir_i, face_width_cfg));
        in_flight++;
      end
      if (res_valid_o === 1'b1 && in_flight > 0) in_flight--;
      if (!start || !busy) begin
        if (dir_backlog.size() > 0 && $urandom_range(99) >= idle_pct &&
            !(dir_backlog[0].drain && in_flight != 0)) begin
          dir_i <= dir_backlog[0].dir;
          start <= 1'b1;
          void'(dir_backlog.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o !== 1'b0) begin
      if (lookup_due.size() == 0) begin
        flag_field("unexpected result, face", 32'hffff_ffff, 32'(res_o.face));
      end else begin
        want = lookup_due.pop_front();
        if (res_o.face !== want.face) flag_field("face", 32'(want.face), 32'(res_o.face));
        if (res_o.texel_x !== want.texel_x)
          flag_field("texel_x", 32'(want.texel_x), 32'(res_o.texel_x));
        if (res_o.texel_y !== want.texel_y)
          flag_field("texel_y", 32'(want.texel_y), 32'(res_o.texel_y));
        if (res_o.invalid !== want.invalid)
          flag_field("invalid", 32'(want.invalid), 32'(res_o.invalid));
      end
    end
  end

  // watchdog: too long without any item, result or register access
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o === 1'b1 || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus: directed set, then random items per face width setting
  initial begin
    dir_t directed_set [$];
    logic [CFG_W-1:0] widths [NUM_PHASES];
    int unsigned idles [NUM_PHASES];
    int ph, i;
    widths = '{13'd1, 13'd0, 13'd4096, 13'd8191, 13'd4095, 13'd2, 13'd3, 13'd256, 13'd0};
    widths[NUM_PHASES-1] = CFG_W'($urandom_range(4, 4094));
    idles = '{71, 30, 0, 71, 30, 0, 71, 30, 0};

    // zero vector, each face at full scale, most negative component
    directed_set.push_back(mk_dir(0, 0, 0));
    directed_set.push_back(mk_dir(32767, 0, 0));
    directed_set.push_back(mk_dir(-32768, 0, 0));
    directed_set.push_back(mk_dir(0, 32767, 0));
    directed_set.push_back(mk_dir(0, -32768, 0));
    directed_set.push_back(mk_dir(0, 0, 32767));
    directed_set.push_back(mk_dir(0, 0, -32768));
    directed_set.push_back(mk_dir(1, 0, 0));
    directed_set.push_back(mk_dir(-1, 0, 0));
    // ties across axes
    directed_set.push_back(mk_dir(5, 5, 5));
    directed_set.push_back(mk_dir(-5, 5, 5));
    directed_set.push_back(mk_dir(0, 7, 7));
    directed_set.push_back(mk_dir(0, -7, -7));
    directed_set.push_back(mk_dir(-32768, -32768, -32768));
    // minors on the clamp edges: lowest clamps to 0, highest to width-1
    directed_set.push_back(mk_dir(100, -100, 100));
    directed_set.push_back(mk_dir(100, 100, -100));
    directed_set.push_back(mk_dir(-32767, 32767, -32767));
    directed_set.push_back(mk_dir(32767, -32768, 12345));
    directed_set.push_back(mk_dir(3, -1, 2));
    directed_set.push_back(mk_dir(-2, 9, -8));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset width, directed set then random; one extra item and about one in fifty random items wait for an empty pipe
    foreach (directed_set[k]) add_item(directed_set[k], 1'b0);
    add_item(mk_dir(-300, 20, 299), 1'b1);
    for (i = 0; i < 200; i++) add_item(rand_direction(), $urandom_range(49) == 0);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      program_face_width(widths[ph]);
      idle_pct = idles[ph];
      if (ph == 0 || ph == 2)
        foreach (directed_set[k]) add_item(directed_set[k], 1'b0);
      for (i = 0; i < 140; i++) add_item(rand_direction(), $urandom_range(49) == 0);
    end

    wait_drained();
    repeat (3 * LATENCY) @(posedge clk_i);
    if (n_fail == 0 && lookup_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
